FILE: sv/blc_pkg.sv
// Shared types and constants for the byte-budget LRU cache.
// Used by every module of the block; depends on nothing.
package blc_pkg;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  localparam int IN_KEY_W = 32;
  localparam int BYTES_W  = 24;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int EVICT_W  = 5;

  localparam int KB = 1024;
  localparam logic [BYTES_W-1:0] CAP_RESET = BYTES_W'(8 * KB * KB);
  localparam logic [EVICT_W-1:0] EVICT_MAX = '1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_LOADED    = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FLUSHED   = 3'd4
  } status_t;

  // Commands to the recency bookkeeping
  typedef enum logic [2:0] {
    REC_NONE,
    REC_HIT,
    REC_EVICT,
    REC_LOAD,
    REC_FLUSH
  } rec_op_t;

  // One finished result
  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [EVICT_W-1:0]   evicted;
    logic [BYTES_W-1:0]   used;
  } res_t;

  // Stored key width: only the low KEY_BITS bits of the key port count
  function automatic int key_width(int key_bits);
    return (key_bits < IN_KEY_W) ? key_bits : IN_KEY_W;
  endfunction

endpackage

FILE: sv/byte_budget_lru_cache.sv
// Byte-budget LRU cache: ENTRIES slots of key and size kept in recency
// order within the capacity_bytes budget, written through the cfg_ port.
// Takes one item at a time. A flush passes S_FLUSH and then S_FINISH.
// An access walks the slots one per cycle through the key memory: a hit
// ends the walk at its slot, a miss walks all ENTRIES slots, and a load
// adds a rank scan and an eviction for every entry it must drop. The
// next item is taken while the result waits in the output register.
// Depends on blc_pkg, blc_store, blc_recency and blc_seq.
module byte_budget_lru_cache import blc_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BYTES_W-1:0]  cfg_data,
  // items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [IN_KEY_W-1:0] in_resource_key,
  input  logic [BYTES_W-1:0]  in_resource_bytes,
  input  logic                in_resource_exists,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot_index,
  output logic [EVICT_W-1:0]  out_evicted_count,
  output logic [BYTES_W-1:0]  out_used_bytes
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = key_width(KEY_BITS);

  logic [BYTES_W-1:0] cap_r;
  logic               out_valid_r;
  res_t               out_r;

  logic               seq_idle;
  logic               res_valid;
  res_t               res;
  logic [IDX_W-1:0]   rd_addr;
  logic [KEY_W-1:0]   key_rd;
  logic [BYTES_W-1:0] size_rd;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W-1:0]   wr_key;
  logic [BYTES_W-1:0] wr_size;
  rec_op_t            rec_op;
  logic [IDX_W-1:0]   op_slot;
  logic [IDX_W-1:0]   qry_idx;
  logic [IDX_W-1:0]   qry_rank;
  logic [ENTRIES-1:0] valid_vec;
  logic [CNT_W-1:0]   valid_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;

  // Hold the byte budget
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_slot_index    = out_r.slot;
  assign out_evicted_count = out_r.evicted;
  assign out_used_bytes    = out_r.used;

  blc_seq #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .idle      (seq_idle),
    .in_mode   (in_mode),
    .in_key    (in_resource_key[KEY_W-1:0]),
    .in_bytes  (in_resource_bytes),
    .in_exists (in_resource_exists),
    .cap       (cap_r),
    .out_free  (!out_valid_r || out_ready),
    .res_valid (res_valid),
    .res       (res),
    .rd_addr   (rd_addr),
    .key_rd    (key_rd),
    .size_rd   (size_rd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_size   (wr_size),
    .rec_op    (rec_op),
    .op_slot   (op_slot),
    .qry_idx   (qry_idx),
    .qry_rank  (qry_rank),
    .valid_vec (valid_vec),
    .valid_cnt (valid_cnt)
  );

  blc_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .key_rd  (key_rd),
    .size_rd (size_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_size (wr_size)
  );

  blc_recency #(
    .ENTRIES (ENTRIES)
  ) u_recency (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_op    (rec_op),
    .op_slot   (op_slot),
    .qry_idx   (qry_idx),
    .qry_rank  (qry_rank),
    .valid_vec (valid_vec),
    .valid_cnt (valid_cnt)
  );

endmodule

FILE: sv/blc_store.sv
// Key and size memories of the cache table, one read and one write port.
// Depends on blc_pkg.
module blc_store import blc_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int IDX_W   = $clog2(ENTRIES),
  localparam int KEY_W   = key_width(KEY_BITS)
) (
  input  logic               clk,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [KEY_W-1:0]   key_rd,
  output logic [BYTES_W-1:0] size_rd,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [KEY_W-1:0]   wr_key,
  input  logic [BYTES_W-1:0] wr_size
);

  logic [KEY_W-1:0]   key_mem  [ENTRIES];
  logic [BYTES_W-1:0] size_mem [ENTRIES];

  // Write on load, read every cycle with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      size_mem[wr_addr] <= wr_size;
    end
    key_rd  <= key_mem[rd_addr];
    size_rd <= size_mem[rd_addr];
  end

endmodule

FILE: sv/blc_recency.sv
// Valid bits, recency ranks and valid count of the cache slots.
// Depends on blc_pkg.
module blc_recency import blc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rec_op_t            rec_op,
  input  logic [IDX_W-1:0]   op_slot,
  input  logic [IDX_W-1:0]   qry_idx,
  output logic [IDX_W-1:0]   qry_rank,
  output logic [ENTRIES-1:0] valid_vec,
  output logic [CNT_W-1:0]   valid_cnt
);

  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   cnt_r;

  assign qry_rank  = rank_r[qry_idx];
  assign valid_vec = valid_r;
  assign valid_cnt = cnt_r;

  // Apply one command per cycle; rank 0 is the most recent entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      case (rec_op)
        REC_HIT: begin
          // age entries newer than the hit one, then make it newest
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (rank_r[i] < qry_rank)) begin
              rank_r[i] <= rank_r[i] + IDX_W'(1);
            end
          end
          rank_r[op_slot] <= '0;
        end
        REC_EVICT: begin
          valid_r[op_slot] <= 1'b0;
          cnt_r            <= cnt_r - CNT_W'(1);
        end
        REC_LOAD: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i]) begin
              rank_r[i] <= rank_r[i] + IDX_W'(1);
            end
          end
          rank_r[op_slot]  <= '0;
          valid_r[op_slot] <= 1'b1;
          cnt_r            <= cnt_r + CNT_W'(1);
        end
        REC_FLUSH: begin
          valid_r <= '0;
          cnt_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/blc_seq.sv
// Sequencer of the cache: scans the slots one per cycle for lookup and
// victim search, and tracks the allocated bytes. Depends on blc_pkg.
module blc_seq import blc_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int IDX_W   = $clog2(ENTRIES),
  localparam int CNT_W   = $clog2(ENTRIES + 1),
  localparam int KEY_W   = key_width(KEY_BITS)
) (
  input  logic               clk,
  input  logic               rst_n,
  // item intake
  input  logic               in_valid,
  output logic               idle,
  input  logic               in_mode,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [BYTES_W-1:0] in_bytes,
  input  logic               in_exists,
  input  logic [BYTES_W-1:0] cap,
  // result handoff
  input  logic               out_free,
  output logic               res_valid,
  output res_t               res,
  // table memories
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [KEY_W-1:0]   key_rd,
  input  logic [BYTES_W-1:0] size_rd,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [KEY_W-1:0]   wr_key,
  output logic [BYTES_W-1:0] wr_size,
  // recency bookkeeping
  output rec_op_t            rec_op,
  output logic [IDX_W-1:0]   op_slot,
  output logic [IDX_W-1:0]   qry_idx,
  input  logic [IDX_W-1:0]   qry_rank,
  input  logic [ENTRIES-1:0] valid_vec,
  input  logic [CNT_W-1:0]   valid_cnt
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_CHECK,
    S_FIT,
    S_EVICT,
    S_EVICT_APPLY,
    S_LOAD,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   idx_r;
  logic               issue_done_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic [IDX_W-1:0]   hit_slot_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_slot_r;
  logic [IDX_W-1:0]   victim_r;
  logic [KEY_W-1:0]   key_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               exists_r;
  logic [BYTES_W-1:0] alloc_r;
  logic [EVICT_W-1:0] evicted_r;
  status_t            status_r;
  logic [SLOT_W-1:0]  slot_r;

  logic               key_match;
  logic [BYTES_W:0]   need_sum;
  logic               need_evict;
  logic [CNT_W-1:0]   oldest_rank;
  logic [EVICT_W-1:0] flush_cnt;

  // Compare the key read back for the slot issued last cycle
  assign key_match = chk_vld_r && valid_vec[chk_idx_r] && (key_rd == key_r);

  // Room check: table full, or the new size does not fit the budget
  assign need_sum   = {1'b0, alloc_r} + {1'b0, bytes_r};
  assign need_evict = (valid_cnt == CNT_W'(ENTRIES)) || (need_sum > {1'b0, cap});

  assign oldest_rank = valid_cnt - CNT_W'(1);
  assign flush_cnt   = (32'(valid_cnt) > 32'(EVICT_MAX)) ? EVICT_MAX
                                                         : EVICT_W'(valid_cnt);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FINISH) && out_free;
  assign res       = '{status: status_r, slot: slot_r, evicted: evicted_r, used: alloc_r};

  assign rd_addr = idx_r;
  assign wr_en   = (state_r == S_LOAD);
  assign wr_addr = free_slot_r;
  assign wr_key  = key_r;
  assign wr_size = bytes_r;

  // Steer recency commands from the current step
  always_comb begin
    rec_op  = REC_NONE;
    op_slot = idx_r;
    qry_idx = idx_r;
    case (state_r)
      S_HIT: begin
        rec_op  = REC_HIT;
        op_slot = hit_slot_r;
        qry_idx = hit_slot_r;
      end
      S_EVICT_APPLY: begin
        rec_op  = REC_EVICT;
        op_slot = victim_r;
      end
      S_LOAD: begin
        rec_op  = REC_LOAD;
        op_slot = free_slot_r;
      end
      S_FLUSH: rec_op = REC_FLUSH;
      default: begin
      end
    endcase
  end

  // Sequencer and its working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_r      <= '0;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r        <= in_key;
            bytes_r      <= in_bytes;
            exists_r     <= in_exists;
            idx_r        <= '0;
            issue_done_r <= 1'b0;
            chk_vld_r    <= 1'b0;
            free_found_r <= 1'b0;
            free_slot_r  <= '0;
            evicted_r    <= '0;
            slot_r       <= '0;
            state_r      <= in_mode ? S_FLUSH : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (key_match) begin
            hit_slot_r <= chk_idx_r;
            state_r    <= S_HIT;
          end else if (chk_vld_r && (chk_idx_r == LAST)) begin
            state_r <= S_CHECK;
          end else begin
            // issue the next slot and note the lowest free one
            chk_vld_r <= !issue_done_r;
            chk_idx_r <= idx_r;
            if (!issue_done_r) begin
              if (!valid_vec[idx_r] && !free_found_r) begin
                free_found_r <= 1'b1;
                free_slot_r  <= idx_r;
              end
              if (idx_r == LAST) begin
                issue_done_r <= 1'b1;
              end else begin
                idx_r <= idx_r + IDX_W'(1);
              end
            end
          end
        end
        S_HIT: begin
          status_r <= ST_HIT;
          slot_r   <= SLOT_W'(hit_slot_r);
          state_r  <= S_FINISH;
        end
        S_CHECK: begin
          if (!exists_r) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_FINISH;
          end else if (bytes_r > cap) begin
            status_r <= ST_TOO_LARGE;
            state_r  <= S_FINISH;
          end else begin
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          idx_r   <= '0;
          state_r <= need_evict ? S_EVICT : S_LOAD;
        end
        S_EVICT: begin
          // the oldest valid entry carries the highest rank
          if (valid_vec[idx_r] && (qry_rank == IDX_W'(oldest_rank))) begin
            victim_r <= idx_r;
            state_r  <= S_EVICT_APPLY;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_EVICT_APPLY: begin
          alloc_r <= alloc_r - size_rd;
          if (evicted_r != EVICT_MAX) begin
            evicted_r <= evicted_r + EVICT_W'(1);
          end
          if (!free_found_r || (victim_r < free_slot_r)) begin
            free_found_r <= 1'b1;
            free_slot_r  <= victim_r;
          end
          state_r <= S_FIT;
        end
        S_LOAD: begin
          alloc_r  <= alloc_r + bytes_r;
          status_r <= ST_LOADED;
          slot_r   <= SLOT_W'(free_slot_r);
          state_r  <= S_FINISH;
        end
        S_FLUSH: begin
          alloc_r   <= '0;
          evicted_r <= flush_cnt;
          status_r  <= ST_FLUSHED;
          state_r   <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
